// ===== rtl/rabs_pkg.sv =====
package rabs_pkg;

  // Default frame geometry.
  localparam int unsigned FRAME_WIDTH_DEF  = 640;
  localparam int unsigned FRAME_HEIGHT_DEF = 480;

  // Field widths.
  localparam int unsigned COL_W      = 10;
  localparam int unsigned ROW_W      = 9;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned THR_W      = 9;
  localparam int unsigned ALPHA_W    = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  // Luma weights in Q0.16, indexed by channel: 0 blue, 1 green, 2 red.
  localparam logic [2:0][15:0] LUMA_W = {16'd19595, 16'd38470, 16'd7471};

  // Unity in Q1.16.
  localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'h10000;

  // Register values after reset.
  localparam logic [COL_W-1:0]          ROI_COL_A_RST = 10'd0;
  localparam logic [COL_W-1:0]          ROI_COL_B_RST = 10'd639;
  localparam logic [ROW_W-1:0]          ROI_ROW_A_RST = 9'd0;
  localparam logic [ROW_W-1:0]          ROI_ROW_B_RST = 9'd479;
  localparam logic signed [THR_W-1:0]   THRESHOLD_RST = 9'sd20;
  localparam logic [ALPHA_W-1:0]        ALPHA_RST     = 17'd2185;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROI_COL_A = 3'd0,
    CFG_ROI_COL_B = 3'd1,
    CFG_ROI_ROW_A = 3'd2,
    CFG_ROI_ROW_B = 3'd3,
    CFG_THRESHOLD = 3'd4,
    CFG_ALPHA     = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_SEGMENT = 1'b1
  } cmd_e;

  // One pixel, channel index 0 blue, 1 green, 2 red.
  typedef logic [2:0][CHAN_W-1:0] rgb_t;

  typedef struct packed {
    cmd_e              command;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } in_item_t;

  typedef struct packed {
    logic foreground;
    logic inside_roi;
  } out_item_t;

endpackage

// ===== rtl/rabs_if.sv =====
interface rabs_in_if import rabs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rabs_out_if import rabs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rabs_bg_ram.sv =====
module rabs_bg_ram import rabs_pkg::*; #(
  parameter int unsigned DEPTH  = FRAME_WIDTH_DEF * FRAME_HEIGHT_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output rgb_t              rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  rgb_t              wr_data_i
);

  rgb_t mem [DEPTH];
  rgb_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read returns the contents from before a write at the same edge.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/running_average_background_subtractor.sv =====
// A pixel passes through the stage 1, 2 and 3 registers and then the output register.
// Throughput: one pixel per cycle unless the output stalls; a pixel directly behind one at the
// same frame address is held while a bubble lets the background write-back settle.
// Reset (rst_ni, asynchronous, active low) clears valid bits and configuration only;
// the background memory is not cleared and an entry is defined once it is loaded.
module running_average_background_subtractor import rabs_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  rabs_in_if.sink               in_i,
  rabs_out_if.source            out_o
);

  localparam int unsigned Depth = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned AddrW = $clog2(Depth);

  // ------------------------------------------------------------------
  // Configuration registers. The user must change them only while the
  // pipeline is empty, not enforced; the datapath reads them directly.
  // ------------------------------------------------------------------
  logic [COL_W-1:0]        roi_col_a_q, roi_col_b_q;
  logic [ROW_W-1:0]        roi_row_a_q, roi_row_b_q;
  logic signed [THR_W-1:0] thr_q;
  logic [ALPHA_W-1:0]      alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roi_col_a_q <= ROI_COL_A_RST;
      roi_col_b_q <= ROI_COL_B_RST;
      roi_row_a_q <= ROI_ROW_A_RST;
      roi_row_b_q <= ROI_ROW_B_RST;
      thr_q       <= THRESHOLD_RST;
      alpha_q     <= ALPHA_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_ROI_COL_A: roi_col_a_q <= cfg_wdata_i[COL_W-1:0];
        CFG_ROI_COL_B: roi_col_b_q <= cfg_wdata_i[COL_W-1:0];
        CFG_ROI_ROW_A: roi_row_a_q <= cfg_wdata_i[ROW_W-1:0];
        CFG_ROI_ROW_B: roi_row_b_q <= cfg_wdata_i[ROW_W-1:0];
        CFG_THRESHOLD: thr_q       <= cfg_wdata_i[THR_W-1:0];
        CFG_ALPHA:     alpha_q     <= cfg_wdata_i[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // A learning rate above one behaves as exactly one.
  logic [ALPHA_W-1:0] alpha_sat;
  assign alpha_sat = (alpha_q > ONE_Q16) ? ONE_Q16 : alpha_q;

  // ------------------------------------------------------------------
  // Pipeline control. The whole pipeline moves together whenever the
  // output register is free or being emptied. The only other hold is the
  // read-after-write hazard: when stage 2 and stage 3 carry the same
  // address and stage 3 may write it, stage 3 retires first and a bubble
  // goes in behind it, after which stage 2 picks the fresh value up from
  // the last-write register.
  // ------------------------------------------------------------------
  logic advance;
  logic hazard;
  logic move_in;

  logic p1_valid_q, p2_valid_q, p3_valid_q, out_valid_q;

  // Stage 1 registers: classified command, address, pixel.
  logic             p1_load_q, p1_seg_q, p1_inside_q;
  logic [AddrW-1:0] p1_addr_q;
  rgb_t             p1_pix_q;

  // Stage 2 registers; the background read lands alongside them.
  logic             p2_load_q, p2_seg_q, p2_inside_q;
  logic [AddrW-1:0] p2_addr_q;
  rgb_t             p2_pix_q;
  rgb_t             rd_data;

  // Stage 3 registers: products ready for the sum and the blend.
  logic                p3_load_q, p3_seg_q, p3_inside_q;
  logic [AddrW-1:0]    p3_addr_q;
  rgb_t                p3_pix_q;
  rgb_t                p3_bg_q;
  logic signed [25:0]  p3_luma_q  [3];
  logic signed [26:0]  p3_blend_q [3];

  out_item_t out_data_q;

  // Last write that went to the memory, for forwarding into stage 2.
  logic             lw_valid_q;
  logic [AddrW-1:0] lw_addr_q;
  rgb_t             lw_data_q;

  logic             wr_en;
  rgb_t             wr_data;

  assign advance = !out_valid_q || out_o.ready;
  assign hazard  = p2_valid_q && p3_valid_q && (p3_load_q || p3_seg_q) &&
                   (p2_addr_q == p3_addr_q);
  assign move_in = advance && !hazard;

  assign in_i.ready = move_in;

  // ------------------------------------------------------------------
  // Stage 0: frame check, region test and address calculation.
  // ------------------------------------------------------------------
  logic [COL_W-1:0] col_lo, col_hi;
  logic [ROW_W-1:0] row_lo, row_hi;
  logic             col_in, row_in, in_frame, inside0;
  logic [AddrW-1:0] addr0;
  rgb_t             pix0;

  always_comb begin
    col_lo = (roi_col_a_q < roi_col_b_q) ? roi_col_a_q : roi_col_b_q;
    col_hi = (roi_col_a_q < roi_col_b_q) ? roi_col_b_q : roi_col_a_q;
    row_lo = (roi_row_a_q < roi_row_b_q) ? roi_row_a_q : roi_row_b_q;
    row_hi = (roi_row_a_q < roi_row_b_q) ? roi_row_b_q : roi_row_a_q;

    // Strict interior: the coordinate is above the low corner and at
    // least two below the high corner.
    col_in = (col_lo < in_i.data.col) &&
             (({1'b0, in_i.data.col} + (COL_W + 1)'(1)) < {1'b0, col_hi});
    row_in = (row_lo < in_i.data.row) &&
             (({1'b0, in_i.data.row} + (ROW_W + 1)'(1)) < {1'b0, row_hi});

    in_frame = (32'(in_i.data.col) < FRAME_WIDTH) && (32'(in_i.data.row) < FRAME_HEIGHT);
    inside0  = in_frame && col_in && row_in;

    // Row-major address; only in-frame pixels use it, and those fit.
    addr0 = AddrW'(in_i.data.row) * AddrW'(FRAME_WIDTH) + AddrW'(in_i.data.col);

    pix0[0] = in_i.data.blue;
    pix0[1] = in_i.data.green;
    pix0[2] = in_i.data.red;
  end

  // ------------------------------------------------------------------
  // Stage 2 datapath: pick the current background, then form channel
  // differences and the luma and blend products in parallel.
  // ------------------------------------------------------------------
  rgb_t               bg2;
  logic signed [8:0]  diff2  [3];
  logic signed [25:0] luma2  [3];
  logic signed [26:0] blend2 [3];

  always_comb begin
    bg2 = (lw_valid_q && (lw_addr_q == p2_addr_q)) ? lw_data_q : rd_data;
    for (int k = 0; k < 3; k++) begin
      diff2[k]  = $signed({1'b0, p2_pix_q[k]}) - $signed({1'b0, bg2[k]});
      luma2[k]  = 26'($signed({1'b0, LUMA_W[k]})) * 26'(diff2[k]);
      blend2[k] = 27'($signed({1'b0, alpha_sat})) * 27'(diff2[k]);
    end
  end

  // ------------------------------------------------------------------
  // Stage 3 datapath: sum the luma difference, compare with the scaled
  // threshold and finish the blend. The blend (a*p + (1-a)*b) >> 16 is
  // b plus the floor of a*(p-b) / 65536.
  // ------------------------------------------------------------------
  logic signed [27:0] luma_sum;
  logic signed [27:0] thr_scaled;
  logic               still;
  logic signed [10:0] blend_sum [3];
  rgb_t               blend3;
  logic               fg3;

  always_comb begin
    luma_sum   = 28'(p3_luma_q[0]) + 28'(p3_luma_q[1]) + 28'(p3_luma_q[2]);
    thr_scaled = {{3{thr_q[THR_W-1]}}, thr_q, 16'd0};
    still      = luma_sum < thr_scaled;
    for (int k = 0; k < 3; k++) begin
      blend_sum[k] = $signed({3'b000, p3_bg_q[k]}) + $signed(p3_blend_q[k][26:16]);
      blend3[k]    = blend_sum[k][7:0];
    end
    fg3     = p3_seg_q && !still;
    wr_en   = advance && p3_valid_q && (p3_load_q || (p3_seg_q && still));
    wr_data = p3_load_q ? p3_pix_q : blend3;
  end

  // ------------------------------------------------------------------
  // Valid bits and the last-write tag.
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      p3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      lw_valid_q  <= 1'b0;
    end else begin
      if (move_in) begin
        p1_valid_q <= in_i.valid;
        p2_valid_q <= p1_valid_q;
      end
      if (advance) begin
        p3_valid_q  <= p2_valid_q && !hazard;
        out_valid_q <= p3_valid_q;
      end
      if (wr_en) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // Payload registers.
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (move_in) begin
      p1_load_q   <= in_frame && (in_i.data.command == CMD_LOAD);
      p1_seg_q    <= inside0 && (in_i.data.command == CMD_SEGMENT);
      p1_inside_q <= inside0;
      p1_addr_q   <= addr0;
      p1_pix_q    <= pix0;

      p2_load_q   <= p1_load_q;
      p2_seg_q    <= p1_seg_q;
      p2_inside_q <= p1_inside_q;
      p2_addr_q   <= p1_addr_q;
      p2_pix_q    <= p1_pix_q;
    end
    if (advance) begin
      p3_load_q   <= p2_load_q;
      p3_seg_q    <= p2_seg_q;
      p3_inside_q <= p2_inside_q;
      p3_addr_q   <= p2_addr_q;
      p3_pix_q    <= p2_pix_q;
      p3_bg_q     <= bg2;
      for (int k = 0; k < 3; k++) begin
        p3_luma_q[k]  <= luma2[k];
        p3_blend_q[k] <= blend2[k];
      end

      out_data_q.foreground <= fg3;
      out_data_q.inside_roi <= p3_inside_q;
    end
    if (wr_en) begin
      lw_addr_q <= p3_addr_q;
      lw_data_q <= wr_data;
    end
  end

  // ------------------------------------------------------------------
  // Background memory: read as the item moves into stage 2, written as
  // it leaves stage 3.
  // ------------------------------------------------------------------
  rabs_bg_ram #(
    .DEPTH  (Depth),
    .ADDR_W (AddrW)
  ) u_bg_ram (
    .clk_i     (clk_i),
    .rd_en_i   (move_in),
    .rd_addr_i (p1_addr_q),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (p3_addr_q),
    .wr_data_i (wr_data)
  );

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ===== rtl/rabs_checker.sv =====
module rabs_checker import rabs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  // Pipeline holds at most one item in each of its four registers.
  localparam int unsigned PipeDepth = 4;

  logic [2:0] count_q, count_d;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_comb begin
    count_d = count_q + 3'(in_xfer) - 3'(out_xfer);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Every result belongs to a pixel taken earlier.
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> (count_q != 3'd0))
    else $error("result transfer without a pixel in flight");

  // No more pixels in flight than the pipeline has registers.
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'(PipeDepth))
    else $error("more pixels in flight than pipeline stages");

  // An empty pipeline always takes a pixel.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 3'd0) |-> in_ready_i)
    else $error("empty pipeline refuses input");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled result changed or dropped");

endmodule

bind running_average_background_subtractor rabs_checker u_rabs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
